// ===== hw/rtl/bls_pkg.sv =====
// ----------------------------------------------------------------------------
// bls_pkg
// Shared item types and operation codes of the bounded shift list.
// ----------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

  localparam int WORD_W   = 32;
  localparam int OP_W     = 3;
  localparam int INDEX_W  = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_AT  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_AT    = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [WORD_W-1:0]  value;
    logic [INDEX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [WORD_W-1:0]   read_word;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic load_back;
    logic shift_up;
    logic shift_down;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bls_cell.sv =====
// ----------------------------------------------------------------------------
// bls_cell
// One storage cell of the list: holds a word, loads it from the new value or
// from the neighbor below or above.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_cell #(
  parameter int POS   = 0,
  parameter int CNT_W = 5
) (
  input  wire                          clk,
  input  wire bls_pkg::cell_ctrl_t     ctrl,
  input  wire [CNT_W-1:0]              back_pos,
  input  wire [CNT_W-1:0]              rm_pos,
  input  wire [bls_pkg::WORD_W-1:0]    value,
  input  wire [bls_pkg::WORD_W-1:0]    left_word,
  input  wire [bls_pkg::WORD_W-1:0]    right_word,
  output logic [bls_pkg::WORD_W-1:0]   word
);

  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(POS);

  always_ff @(posedge clk) begin
    if (ctrl.shift_up) begin
      word <= left_word;
    end else if (ctrl.load_back && back_pos == MY_POS) begin
      word <= value;
    end else if (ctrl.shift_down && MY_POS >= rm_pos) begin
      word <= right_word;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_shift_list.sv =====
// ----------------------------------------------------------------------------
// bounded_shift_list
// Ordered list of up to CAPACITY words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request item (op, value, index) is taken on a rising edge with start
//   high and busy low. Ops: push back, push front, pop back, pop front,
//   remove at index, clear, read at index.
//   Exactly one result item (count, read_word, status) appears on rsp in the
//   cycle after the request, marked by done for a single cycle.
//   One request may be issued every cycle while busy is low: the cells
//   that move shift to their neighbors in parallel in the request's cycle.
//   The read path is a single word select over the first 16 cells.
//   Status: ok, full (push dropped, list unchanged), or empty / index out of
//   range (list unchanged). read_word is zero except for a good read.
//   Reset empties the list and holds busy high while rst is high and for the
//   first cycle after it; cell contents are not cleared and are never seen
//   before being written.
//   Results cannot be stalled: the receiver must take each one as it comes.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_shift_list #(
  parameter int CAPACITY = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire bls_pkg::req_t  req,
  output logic                busy,
  output logic                done,
  output bls_pkg::rsp_t       rsp
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int IW    = (CW > bls_pkg::INDEX_W) ? CW : bls_pkg::INDEX_W;
  localparam int RD_N  = 1 << bls_pkg::INDEX_W;

  logic [CW-1:0]                used;
  logic [CW-1:0]                used_next;
  logic [bls_pkg::WORD_W-1:0]   words [CAPACITY];
  logic [bls_pkg::WORD_W-1:0]   rd_words [RD_N];
  bls_pkg::cell_ctrl_t          ctrl;
  bls_pkg::rsp_t                rsp_next;
  logic [CW-1:0]                rm_pos;
  logic                         accept;
  logic                         full;
  logic                         empty;
  logic                         index_ok;

  assign accept   = start && !busy;
  assign full     = (used == CW'(CAPACITY));
  assign empty    = (used == '0);
  assign index_ok = (IW'(req.index) < IW'(used));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [bls_pkg::WORD_W-1:0] left_word;
    logic [bls_pkg::WORD_W-1:0] right_word;
    if (i == 0) begin : g_first
      assign left_word = req.value;
    end else begin : g_mid
      assign left_word = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_word = words[i];
    end else begin : g_inner
      assign right_word = words[i+1];
    end
    bls_cell #(
      .POS   (i),
      .CNT_W (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .back_pos   (used),
      .rm_pos     (rm_pos),
      .value      (req.value),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (words[i])
    );
  end

  for (genvar j = 0; j < RD_N; j++) begin : g_rd
    if (j < CAPACITY) begin : g_hit
      assign rd_words[j] = words[j];
    end else begin : g_none
      assign rd_words[j] = '0;
    end
  end

  always_comb begin
    ctrl               = '0;
    rm_pos             = '0;
    used_next          = used;
    rsp_next.read_word = '0;
    rsp_next.status    = bls_pkg::ST_OK;
    case (req.op)
      bls_pkg::OP_PUSH_BACK: begin
        if (full) begin
          rsp_next.status = bls_pkg::ST_FULL;
        end else begin
          ctrl.load_back = accept;
          used_next      = used + 1'b1;
        end
      end
      bls_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          rsp_next.status = bls_pkg::ST_FULL;
        end else begin
          ctrl.shift_up = accept;
          used_next     = used + 1'b1;
        end
      end
      bls_pkg::OP_POP_BACK: begin
        if (empty) begin
          rsp_next.status = bls_pkg::ST_EMPTY;
        end else begin
          used_next = used - 1'b1;
        end
      end
      bls_pkg::OP_POP_FRONT: begin
        if (empty) begin
          rsp_next.status = bls_pkg::ST_EMPTY;
        end else begin
          ctrl.shift_down = accept;
          used_next       = used - 1'b1;
        end
      end
      bls_pkg::OP_REMOVE_AT: begin
        if (!index_ok) begin
          rsp_next.status = bls_pkg::ST_EMPTY;
        end else begin
          ctrl.shift_down = accept;
          rm_pos          = CW'(IW'(req.index));
          used_next       = used - 1'b1;
        end
      end
      bls_pkg::OP_CLEAR: begin
        used_next = '0;
      end
      bls_pkg::OP_READ_AT: begin
        if (!index_ok) begin
          rsp_next.status = bls_pkg::ST_EMPTY;
        end else begin
          rsp_next.read_word = rd_words[req.index];
        end
      end
      default: begin
      end
    endcase
    rsp_next.count = bls_pkg::COUNT_W'(used_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      done <= accept;
      if (accept) begin
        used <= used_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted item gave no result");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == bls_pkg::ST_FULL) |-> used == CW'(CAPACITY))
    else $error("full status with room left");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != bls_pkg::ST_OK) |-> rsp.read_word == '0)
    else $error("read word set on failed item");

endmodule

`default_nettype wire
